// ----- design/pan_tilt_jog_controller_unit_macros.svh -----
// assertion macros shared by the checker
`ifndef PAN_TILT_JOG_CONTROLLER_UNIT_MACROS_SVH
`define PAN_TILT_JOG_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication
`define PTJ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ptj assertion failed");

// next-cycle implication
`define PTJ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ptj assertion failed");

`endif

// ----- design/ptj_pkg.sv -----
package ptj_pkg;

	localparam int ANGLE_W   = 16;
	localparam int STEP_W    = 12;
	localparam int KEY_W     = 4;
	localparam int LEVEL_W   = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam int FIFO_DEPTH_DEF = 4;

	// key codes
	localparam logic [KEY_W-1:0] KEY_UP     = 4'd0;
	localparam logic [KEY_W-1:0] KEY_LEFT   = 4'd1;
	localparam logic [KEY_W-1:0] KEY_DOWN   = 4'd2;
	localparam logic [KEY_W-1:0] KEY_RIGHT  = 4'd3;
	localparam logic [KEY_W-1:0] KEY_CENTRE = 4'd4;
	localparam logic [KEY_W-1:0] KEY_SAVE   = 4'd5;
	localparam logic [KEY_W-1:0] KEY_RECALL = 4'd6;
	localparam logic [KEY_W-1:0] KEY_QUIT   = 4'd7;
	localparam logic [KEY_W-1:0] KEY_ESCAPE = 4'd8;

	// key levels
	localparam logic [LEVEL_W-1:0] LVL_PRESS  = 2'd1;
	localparam logic [LEVEL_W-1:0] LVL_REPEAT = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTRE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PAN_LOWER  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PAN_UPPER  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TILT_LOWER = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TILT_UPPER = 3'd5;

	// reset values
	localparam logic [STEP_W-1:0]  STEP_RESET       = 12'd256;
	localparam logic [ANGLE_W-1:0] CENTRE_RESET     = 16'd23040;
	localparam logic [ANGLE_W-1:0] PAN_LOWER_RESET  = 16'd17920;
	localparam logic [ANGLE_W-1:0] PAN_UPPER_RESET  = 16'd43520;
	localparam logic [ANGLE_W-1:0] TILT_LOWER_RESET = 16'd0;
	localparam logic [ANGLE_W-1:0] TILT_UPPER_RESET = 16'd46080;
	localparam logic [ANGLE_W-1:0] POSITION_RESET   = 16'd23040;

	// diagonal step is step * 181 / 256
	localparam int DIAG_NUM_W = 8;
	localparam logic [DIAG_NUM_W-1:0] DIAG_NUM = 8'd181;
	localparam logic [STEP_W-1:0] DIAG_RESET = STEP_W'((256 * 181) / 256);

	typedef enum logic [1:0] {
		GRP_NONE,
		GRP_DIR,
		GRP_CMD,
		GRP_QUIT
	} ptj_grp_t;

	typedef struct packed {
		logic       tick;
		ptj_grp_t   grp;
		logic [3:0] mask;
		logic       held;
	} ptj_req_t;

endpackage

// ----- design/ptj_fifo.sv -----
module ptj_fifo #(
	parameter int DEPTH = ptj_pkg::FIFO_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ptj_pkg::ptj_req_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output ptj_pkg::ptj_req_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ptj_pkg::ptj_req_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/ptj_front.sv -----
module ptj_front (
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              func,
	input  logic [ptj_pkg::KEY_W-1:0]         key_id,
	input  logic [ptj_pkg::LEVEL_W-1:0]       key_level,
	input  logic                              full,
	output logic                              push,
	output ptj_pkg::ptj_req_t                 req
);

	assign in_ready = !full;
	assign push     = in_valid && !full;

	always_comb begin
		req.tick = func;
		req.held = key_level inside {ptj_pkg::LVL_PRESS, ptj_pkg::LVL_REPEAT};
		req.grp  = ptj_pkg::GRP_NONE;
		req.mask = 4'b0000;
		if (!func) begin
			case (key_id)
				ptj_pkg::KEY_UP: begin
					req.grp  = ptj_pkg::GRP_DIR;
					req.mask = 4'b0001;
				end
				ptj_pkg::KEY_LEFT: begin
					req.grp  = ptj_pkg::GRP_DIR;
					req.mask = 4'b0010;
				end
				ptj_pkg::KEY_DOWN: begin
					req.grp  = ptj_pkg::GRP_DIR;
					req.mask = 4'b0100;
				end
				ptj_pkg::KEY_RIGHT: begin
					req.grp  = ptj_pkg::GRP_DIR;
					req.mask = 4'b1000;
				end
				ptj_pkg::KEY_CENTRE: begin
					req.grp  = ptj_pkg::GRP_CMD;
					req.mask = 4'b0001;
				end
				ptj_pkg::KEY_SAVE: begin
					req.grp  = ptj_pkg::GRP_CMD;
					req.mask = 4'b0010;
				end
				ptj_pkg::KEY_RECALL: begin
					req.grp  = ptj_pkg::GRP_CMD;
					req.mask = 4'b0100;
				end
				ptj_pkg::KEY_QUIT: begin
					req.grp  = ptj_pkg::GRP_QUIT;
					req.mask = 4'b0001;
				end
				ptj_pkg::KEY_ESCAPE: begin
					req.grp  = ptj_pkg::GRP_QUIT;
					req.mask = 4'b0010;
				end
				default: begin
					req.grp  = ptj_pkg::GRP_NONE;
					req.mask = 4'b0000;
				end
			endcase
		end
	end

endmodule

// ----- design/ptj_back.sv -----
module ptj_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_en,
	input  logic [ptj_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  logic [ptj_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                head_valid,
	input  ptj_pkg::ptj_req_t                   head,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ptj_pkg::ANGLE_W-1:0]         pan_angle,
	output logic [ptj_pkg::ANGLE_W-1:0]         tilt_angle,
	output logic                                halted,
	output logic [3:0]                          held_keys
);

	localparam int AW   = ptj_pkg::ANGLE_W;
	localparam int SW   = ptj_pkg::STEP_W;
	localparam int SUMW = AW + 2;
	localparam int PRODW = SW + ptj_pkg::DIAG_NUM_W;

	logic [SW-1:0] step_q;
	logic [SW-1:0] diag_q;
	logic [AW-1:0] centre_q;
	logic [AW-1:0] pan_lower_q;
	logic [AW-1:0] pan_upper_q;
	logic [AW-1:0] tilt_lower_q;
	logic [AW-1:0] tilt_upper_q;

	logic [3:0]    dir_q;
	logic [2:0]    cmd_q;
	logic [1:0]    quit_q;
	logic          halt_q;
	logic [AW-1:0] pan_q;
	logic [AW-1:0] tilt_q;
	logic [AW-1:0] pan_mem_q;
	logic [AW-1:0] tilt_mem_q;

	logic          out_valid_q;
	logic [AW-1:0] pan_angle_q;
	logic [AW-1:0] tilt_angle_q;
	logic          halted_q;
	logic [3:0]    held_keys_q;

	logic [PRODW-1:0]      step_prod;
	logic                  halt_next;
	logic [AW-1:0]         base_pan;
	logic [AW-1:0]         base_tilt;
	logic                  move_x;
	logic                  move_y;
	logic [SW-1:0]         mv;
	logic signed [SUMW-1:0] mv_s;
	logic signed [SUMW-1:0] pan_sum;
	logic signed [SUMW-1:0] tilt_sum;
	logic [AW-1:0]         pan_new;
	logic [AW-1:0]         tilt_new;
	logic                  tick_pop;

	function automatic logic [AW-1:0] clamp_axis(
		input logic signed [SUMW-1:0] v,
		input logic [AW-1:0]          lo,
		input logic [AW-1:0]          hi
	);
		logic signed [SUMW-1:0] t;
		t = v;
		if (t < $signed({2'b00, lo})) begin
			t = $signed({2'b00, lo});
		end
		if (t > $signed({2'b00, hi})) begin
			t = $signed({2'b00, hi});
		end
		return t[AW-1:0];
	endfunction

	assign step_prod = {{ptj_pkg::DIAG_NUM_W{1'b0}}, cfg_data[SW-1:0]}
		* {{SW{1'b0}}, ptj_pkg::DIAG_NUM};

	assign pop      = head_valid && (!head.tick || !out_valid_q || out_ready);
	assign tick_pop = pop && head.tick;

	always_comb begin
		halt_next = halt_q || (quit_q != 2'b00);
		// recall after save reads the freshly saved position
		if (cmd_q[2]) begin
			base_pan  = cmd_q[1] ? pan_q : pan_mem_q;
			base_tilt = cmd_q[1] ? tilt_q : tilt_mem_q;
		end else if (cmd_q[0]) begin
			base_pan  = centre_q;
			base_tilt = centre_q;
		end else begin
			base_pan  = pan_q;
			base_tilt = tilt_q;
		end
		move_x = dir_q[1] ^ dir_q[3];
		move_y = dir_q[0] ^ dir_q[2];
		mv     = (move_x && move_y) ? diag_q : step_q;
		mv_s   = $signed({{(SUMW - SW){1'b0}}, mv});
		pan_sum  = $signed({2'b00, base_pan});
		tilt_sum = $signed({2'b00, base_tilt});
		if (move_x) begin
			pan_sum = dir_q[1] ? pan_sum + mv_s : pan_sum - mv_s;
		end
		if (move_y) begin
			tilt_sum = dir_q[0] ? tilt_sum + mv_s : tilt_sum - mv_s;
		end
		pan_new  = clamp_axis(pan_sum, pan_lower_q, pan_upper_q);
		tilt_new = clamp_axis(tilt_sum, tilt_lower_q, tilt_upper_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= ptj_pkg::STEP_RESET;
			diag_q       <= ptj_pkg::DIAG_RESET;
			centre_q     <= ptj_pkg::CENTRE_RESET;
			pan_lower_q  <= ptj_pkg::PAN_LOWER_RESET;
			pan_upper_q  <= ptj_pkg::PAN_UPPER_RESET;
			tilt_lower_q <= ptj_pkg::TILT_LOWER_RESET;
			tilt_upper_q <= ptj_pkg::TILT_UPPER_RESET;
		end else if (cfg_en) begin
			case (cfg_addr)
				ptj_pkg::CFG_STEP_SIZE: begin
					step_q <= cfg_data[SW-1:0];
					diag_q <= step_prod[PRODW-1:ptj_pkg::DIAG_NUM_W];
				end
				ptj_pkg::CFG_CENTRE:     centre_q     <= cfg_data;
				ptj_pkg::CFG_PAN_LOWER:  pan_lower_q  <= cfg_data;
				ptj_pkg::CFG_PAN_UPPER:  pan_upper_q  <= cfg_data;
				ptj_pkg::CFG_TILT_LOWER: tilt_lower_q <= cfg_data;
				ptj_pkg::CFG_TILT_UPPER: tilt_upper_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q      <= 4'b0000;
			cmd_q      <= 3'b000;
			quit_q     <= 2'b00;
			halt_q     <= 1'b0;
			pan_q      <= ptj_pkg::POSITION_RESET;
			tilt_q     <= ptj_pkg::POSITION_RESET;
			pan_mem_q  <= ptj_pkg::POSITION_RESET;
			tilt_mem_q <= ptj_pkg::POSITION_RESET;
		end else if (pop) begin
			if (head.tick) begin
				halt_q <= halt_next;
				cmd_q  <= 3'b000;
				if (!halt_next) begin
					pan_q  <= pan_new;
					tilt_q <= tilt_new;
					if (cmd_q[1]) begin
						pan_mem_q  <= pan_q;
						tilt_mem_q <= tilt_q;
					end
				end
			end else begin
				case (head.grp)
					ptj_pkg::GRP_DIR: begin
						dir_q <= head.held ? (dir_q | head.mask) : (dir_q & ~head.mask);
					end
					ptj_pkg::GRP_CMD: begin
						cmd_q <= head.held ? (cmd_q | head.mask[2:0])
							: (cmd_q & ~head.mask[2:0]);
					end
					ptj_pkg::GRP_QUIT: begin
						quit_q <= head.held ? (quit_q | head.mask[1:0])
							: (quit_q & ~head.mask[1:0]);
					end
					default: begin
					end
				endcase
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_pop) begin
			pan_angle_q  <= halt_next ? pan_q : pan_new;
			tilt_angle_q <= halt_next ? tilt_q : tilt_new;
			halted_q     <= halt_next;
			held_keys_q  <= dir_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign pan_angle  = pan_angle_q;
	assign tilt_angle = tilt_angle_q;
	assign halted     = halted_q;
	assign held_keys  = held_keys_q;

endmodule

// ----- design/pan_tilt_jog_controller_unit.sv -----
// Jog setpoint controller for a two-axis pan/tilt mount, angles in unsigned Q8.8 degrees.
// Requests on the input channel are either key events (func 0), which update the held
// direction keys, the pending centre/save/recall commands and the quit/escape keys, or
// control ticks (func 1), each of which yields exactly one result with the new clamped
// pan and tilt setpoints, the sticky halted flag and the held direction keys. The front
// decodes each request and drops it into a queue of FIFO_DEPTH entries; the back retires
// one request per clock unless a tick waits on a stalled result register, so a request
// can be taken every cycle. A tick leaves the queue once the result register is free or
// being emptied; only a stalled result register slows the input side, once the queue has
// filled. Configuration writes take effect at once and are meant for idle periods;
// step_size also loads the diagonal step, step * 181 / 256, on the same write.
module pan_tilt_jog_controller_unit #(
	parameter int FIFO_DEPTH = ptj_pkg::FIFO_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_en,
	input  logic [ptj_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  logic [ptj_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            func,
	input  logic [ptj_pkg::KEY_W-1:0]       key_id,
	input  logic [ptj_pkg::LEVEL_W-1:0]     key_level,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ptj_pkg::ANGLE_W-1:0]     pan_angle,
	output logic [ptj_pkg::ANGLE_W-1:0]     tilt_angle,
	output logic                            halted,
	output logic [3:0]                      held_keys
);

	logic              fifo_full;
	logic              fifo_empty;
	logic              push;
	logic              pop;
	ptj_pkg::ptj_req_t req;
	ptj_pkg::ptj_req_t head;

	ptj_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.key_id    (key_id),
		.key_level (key_level),
		.full      (fifo_full),
		.push      (push),
		.req       (req)
	);

	ptj_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (req),
		.full      (fifo_full),
		.pop       (pop),
		.empty     (fifo_empty),
		.head      (head)
	);

	ptj_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_en     (cfg_en),
		.cfg_addr   (cfg_addr),
		.cfg_data   (cfg_data),
		.head_valid (!fifo_empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pan_angle  (pan_angle),
		.tilt_angle (tilt_angle),
		.halted     (halted),
		.held_keys  (held_keys)
	);

endmodule

// ----- design/ptj_checker.sv -----
`include "pan_tilt_jog_controller_unit_macros.svh"

module ptj_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            func,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [ptj_pkg::ANGLE_W-1:0]     pan_angle,
	input logic [ptj_pkg::ANGLE_W-1:0]     tilt_angle,
	input logic                            halted
);

	logic                        in_tick;
	logic                        out_take;
	logic [7:0]                  ticks_q;
	logic                        halt_seen_q;
	logic [ptj_pkg::ANGLE_W-1:0] pan_frozen_q;
	logic [ptj_pkg::ANGLE_W-1:0] tilt_frozen_q;

	assign in_tick  = in_valid && in_ready && func;
	assign out_take = out_valid && out_ready;

	// ticks taken whose result has not left yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= '0;
		end else if (in_tick && !out_take) begin
			ticks_q <= ticks_q + 1'b1;
		end else if (out_take && !in_tick) begin
			ticks_q <= ticks_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halt_seen_q <= 1'b0;
		end else if (out_take && halted) begin
			halt_seen_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take && halted && !halt_seen_q) begin
			pan_frozen_q  <= pan_angle;
			tilt_frozen_q <= tilt_angle;
		end
	end

	`PTJ_ASSERT_NOW(a_result_needs_tick, clk, arst_n, out_valid, ticks_q != 8'd0)
	`PTJ_ASSERT_NOW(a_halt_sticky, clk, arst_n, out_valid && halt_seen_q, halted)
	`PTJ_ASSERT_NOW(a_halt_frozen, clk, arst_n, out_valid && halt_seen_q,
		pan_angle == pan_frozen_q && tilt_angle == tilt_frozen_q)
	`PTJ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(pan_angle) && $stable(tilt_angle) && $stable(halted))

endmodule

bind pan_tilt_jog_controller_unit ptj_checker u_ptj_checker (.*);

// ----- sim/pan_tilt_jog_controller_unit_tb.sv -----
`timescale 1ns / 1ps

package jog_tb_pkg;
	import ptj_pkg::*;

	localparam logic FUNC_KEY  = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	localparam logic [LEVEL_W-1:0] LVL_RELEASE = 2'd0;
	localparam logic [LEVEL_W-1:0] LVL_BOGUS   = 2'd3;

	localparam int CMD_CENTRE = 0;
	localparam int CMD_SAVE   = 1;
	localparam int CMD_RECALL = 2;

	localparam int DIAG_SHIFT = 8;

	typedef struct packed {
		logic [ANGLE_W-1:0] pan;
		logic [ANGLE_W-1:0] tilt;
		logic               halted;
		logic [3:0]         held;
	} setpoint_t;

	class jog_setpoint_tracker;
		logic [STEP_W-1:0]  step_size;
		logic [ANGLE_W-1:0] centre, pan_lo, pan_hi, tilt_lo, tilt_hi;
		logic [3:0]         dir_held;
		logic [2:0]         cmd_pending;
		logic [1:0]         stop_keys;
		logic               frozen;
		logic [ANGLE_W-1:0] pan_pos, tilt_pos, pan_mem, tilt_mem;
		setpoint_t          setpoints_due[$];
		int unsigned        mismatches, requests_seen, setpoints_checked;
		int unsigned        diagonal_ticks, clamp_hits;

		function new();
			step_size = STEP_RESET;
			centre = CENTRE_RESET;
			pan_lo = PAN_LOWER_RESET;
			pan_hi = PAN_UPPER_RESET;
			tilt_lo = TILT_LOWER_RESET;
			tilt_hi = TILT_UPPER_RESET;
			dir_held = '0;
			cmd_pending = '0;
			stop_keys = '0;
			frozen = 1'b0;
			pan_pos = POSITION_RESET;
			tilt_pos = POSITION_RESET;
			pan_mem = POSITION_RESET;
			tilt_mem = POSITION_RESET;
			mismatches = 0;
			requests_seen = 0;
			setpoints_checked = 0;
			diagonal_ticks = 0;
			clamp_hits = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_STEP_SIZE:  step_size = data[STEP_W-1:0];
				CFG_CENTRE:     centre = data;
				CFG_PAN_LOWER:  pan_lo = data;
				CFG_PAN_UPPER:  pan_hi = data;
				CFG_TILT_LOWER: tilt_lo = data;
				CFG_TILT_UPPER: tilt_hi = data;
				default: ;
			endcase
		endfunction

		function logic [ANGLE_W-1:0] clamp_axis(int v, logic [ANGLE_W-1:0] lo,
				logic [ANGLE_W-1:0] hi);
			int r;
			r = v;
			if (r < int'(lo)) r = int'(lo);
			if (r > int'(hi)) r = int'(hi);
			if (r != v) clamp_hits++;
			return r[ANGLE_W-1:0];
		endfunction

		function int pending();
			return setpoints_due.size();
		endfunction

		function void note_request(logic f, logic [KEY_W-1:0] k, logic [LEVEL_W-1:0] lvl);
			logic held;
			int dx, dy, mv, pan_t, tilt_t;
			requests_seen++;
			if (f == FUNC_KEY) begin
				held = (lvl == LVL_PRESS) || (lvl == LVL_REPEAT);
				if (k <= KEY_RIGHT)
					dir_held[k[1:0]] = held;
				else if (k <= KEY_RECALL)
					cmd_pending[2'(k - KEY_CENTRE)] = held;
				else if (k <= KEY_ESCAPE)
					stop_keys[1'(k - KEY_QUIT)] = held;
				return;
			end
			if (stop_keys != '0) frozen = 1'b1;
			if (!frozen) begin
				pan_t = int'(pan_pos);
				tilt_t = int'(tilt_pos);
				if (cmd_pending[CMD_CENTRE]) begin
					pan_t = int'(centre);
					tilt_t = int'(centre);
				end
				if (cmd_pending[CMD_SAVE]) begin
					pan_mem = pan_pos;
					tilt_mem = tilt_pos;
				end
				if (cmd_pending[CMD_RECALL]) begin
					pan_t = int'(pan_mem);
					tilt_t = int'(tilt_mem);
				end
				dx = int'(dir_held[KEY_LEFT]) - int'(dir_held[KEY_RIGHT]);
				dy = int'(dir_held[KEY_UP]) - int'(dir_held[KEY_DOWN]);
				if (dx != 0 && dy != 0) begin
					mv = (int'(step_size) * int'(DIAG_NUM)) >> DIAG_SHIFT;
					diagonal_ticks++;
				end else begin
					mv = int'(step_size);
				end
				pan_pos = clamp_axis(pan_t + dx * mv, pan_lo, pan_hi);
				tilt_pos = clamp_axis(tilt_t + dy * mv, tilt_lo, tilt_hi);
			end
			cmd_pending = '0;
			setpoints_due.push_back('{pan: pan_pos, tilt: tilt_pos, halted: frozen,
				held: dir_held});
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= 50) $display("[%0t] mismatch: %s", $time, msg);
		endtask

		task check_setpoint(setpoint_t got);
			setpoint_t want;
			if (setpoints_due.size() == 0) begin
				report($sformatf("setpoint pan %0d tilt %0d arrived with none due",
					got.pan, got.tilt));
				return;
			end
			want = setpoints_due.pop_front();
			setpoints_checked++;
			if (got.pan !== want.pan)
				report($sformatf("pan_angle %0d, want %0d", got.pan, want.pan));
			if (got.tilt !== want.tilt)
				report($sformatf("tilt_angle %0d, want %0d", got.tilt, want.tilt));
			if (got.halted !== want.halted)
				report($sformatf("halted %b, want %b", got.halted, want.halted));
			if (got.held !== want.held)
				report($sformatf("held_keys %b, want %b", got.held, want.held));
		endtask
	endclass
endpackage

module pan_tilt_jog_controller_unit_tb;
	import ptj_pkg::*;
	import jog_tb_pkg::*;

	localparam int STALL_LIMIT     = 3000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES   = 12;
	localparam int PHASE_ITEMS     = 120;
	localparam int NUM_PHASES      = 8;
	localparam int ANGLE_MAX       = 46080;
	localparam int STEP_MAX        = 2560;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_en;
	logic [CFG_IDX_W-1:0]  cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  func;
	logic [KEY_W-1:0]      key_id;
	logic [LEVEL_W-1:0]    key_level;
	logic                  out_valid;
	logic                  out_ready;
	logic [ANGLE_W-1:0]    pan_angle;
	logic [ANGLE_W-1:0]    tilt_angle;
	logic                  halted;
	logic [3:0]            held_keys;

	jog_setpoint_tracker tracker = new();

	bit          idling = 1'b1;
	bit          hold_off_pending = 1'b0;
	int unsigned settings_loaded = 0;
	int unsigned quiet_cycles = 0;

	pan_tilt_jog_controller_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_en     (cfg_en),
		.cfg_addr   (cfg_addr),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.key_id     (key_id),
		.key_level  (key_level),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pan_angle  (pan_angle),
		.tilt_angle (tilt_angle),
		.halted     (halted),
		.held_keys  (held_keys)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin : monitor
		setpoint_t seen;
		if (arst_n) begin
			if (in_valid && in_ready) tracker.note_request(func, key_id, key_level);
			if (out_valid && out_ready) begin
				seen.pan = pan_angle;
				seen.tilt = tilt_angle;
				seen.halted = halted;
				seen.held = held_keys;
				tracker.check_setpoint(seen);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("[%0t] no progress for %0d cycles", $time, STALL_LIMIT);
					$display("*** FAILED ***");
					$finish;
				end
			end
		end
	end

	// result side
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				out_ready <= 1'b1;
			end else if (idling && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12) - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_request(input logic f, input logic [KEY_W-1:0] k,
			input logic [LEVEL_W-1:0] lvl);
		if (idling && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		key_id <= k;
		key_level <= lvl;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic key_event(input logic [KEY_W-1:0] k, input logic [LEVEL_W-1:0] lvl);
		send_request(FUNC_KEY, k, lvl);
	endtask

	task automatic tick();
		send_request(FUNC_TICK, KEY_W'($urandom_range(0, 15)),
			LEVEL_W'($urandom_range(0, 3)));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
		cfg_en <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= CFG_DATA_W'(data);
		tracker.write_reg(idx, CFG_DATA_W'(data));
		@(negedge clk);
	endtask

	task automatic load_settings(input int unsigned step, input int unsigned ctr,
			input int unsigned pl, input int unsigned ph,
			input int unsigned tl, input int unsigned th);
		write_reg(CFG_STEP_SIZE, step);
		write_reg(CFG_CENTRE, ctr);
		write_reg(CFG_PAN_LOWER, pl);
		write_reg(CFG_PAN_UPPER, ph);
		write_reg(CFG_TILT_LOWER, tl);
		write_reg(CFG_TILT_UPPER, th);
		cfg_en <= 1'b0;
		settings_loaded++;
	endtask

	task automatic random_limits(output int unsigned lo, output int unsigned hi);
		int unsigned a, b;
		a = $urandom_range(0, ANGLE_MAX);
		b = $urandom_range(0, ANGLE_MAX);
		if (a > b && $urandom_range(0, 3) != 0) begin
			lo = b;
			hi = a;
		end else begin
			lo = a;
			hi = b;
		end
	endtask

	task automatic random_item();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			tick();
		end else if (pick < 65) begin
			key_event(KEY_W'($urandom_range(KEY_UP, KEY_RIGHT)),
				LEVEL_W'($urandom_range(0, 3)));
		end else if (pick < 85) begin
			key_event(KEY_W'($urandom_range(KEY_CENTRE, KEY_RECALL)),
				LEVEL_W'($urandom_range(0, 3)));
		end else if (pick < 92) begin
			key_event(KEY_W'($urandom_range(KEY_ESCAPE + 1, 15)),
				LEVEL_W'($urandom_range(0, 3)));
		end else begin
			// stop key pressed and let go before any tick sees it
			pick = $urandom_range(KEY_QUIT, KEY_ESCAPE);
			key_event(KEY_W'(pick), $urandom_range(0, 1) ? LVL_PRESS : LVL_REPEAT);
			key_event(KEY_W'(pick), $urandom_range(0, 1) ? LVL_RELEASE : LVL_BOGUS);
		end
	endtask

	initial begin
		int unsigned step, ctr, pl, ph, tl, th;
		arst_n = 1'b0;
		cfg_en = 1'b0;
		cfg_addr = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		func = FUNC_KEY;
		key_id = KEY_UP;
		key_level = LVL_RELEASE;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		load_settings(STEP_RESET, CENTRE_RESET, PAN_LOWER_RESET, PAN_UPPER_RESET,
			TILT_LOWER_RESET, TILT_UPPER_RESET);
		tick();
		key_event(KEY_LEFT, LVL_PRESS);
		key_event(KEY_UP, LVL_REPEAT);
		tick();
		key_event(KEY_RIGHT, LVL_PRESS);
		tick();
		key_event(KEY_LEFT, LVL_RELEASE);
		key_event(KEY_DOWN, LVL_REPEAT);
		tick();
		key_event(KEY_UP, LVL_BOGUS);
		key_event(4'd15, LVL_PRESS);
		tick();
		key_event(KEY_SAVE, LVL_PRESS);
		key_event(KEY_CENTRE, LVL_PRESS);
		key_event(KEY_CENTRE, LVL_RELEASE);
		tick();
		key_event(KEY_CENTRE, LVL_REPEAT);
		tick();
		key_event(KEY_RECALL, LVL_PRESS);
		key_event(KEY_SAVE, LVL_PRESS);
		tick();
		key_event(KEY_ESCAPE, LVL_PRESS);
		key_event(KEY_ESCAPE, LVL_RELEASE);
		key_event(KEY_QUIT, LVL_REPEAT);
		key_event(KEY_QUIT, LVL_BOGUS);
		tick();

		for (int p = 1; p <= NUM_PHASES; p++) begin
			wait_drained();
			idling = (p % 3 != 1);
			case (p)
				1: load_settings(0, 0, 0, ANGLE_MAX, 0, ANGLE_MAX);
				2: load_settings(4095, ANGLE_MAX, 0, ANGLE_MAX, 0, ANGLE_MAX);
				3: load_settings(STEP_MAX, 12800, 30000, 20000, ANGLE_MAX, 0);
				4: begin
					random_limits(pl, ph);
					random_limits(tl, th);
					load_settings(1, $urandom_range(0, ANGLE_MAX), pl, ph, tl, th);
				end
				default: begin
					random_limits(pl, ph);
					random_limits(tl, th);
					step = $urandom_range(1, STEP_MAX);
					ctr = $urandom_range(0, ANGLE_MAX);
					load_settings(step, ctr, pl, ph, tl, th);
				end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 2 && i == 40) hold_off_pending = 1'b1;
				if (p == 4 && i == 60) wait_drained();
				random_item();
			end
		end

		// final stretch at full rate, ending with the mount halted
		wait_drained();
		idling = 1'b0;
		random_limits(pl, ph);
		random_limits(tl, th);
		load_settings($urandom_range(1, STEP_MAX), $urandom_range(0, ANGLE_MAX),
			pl, ph, tl, th);
		for (int i = 0; i < 20; i++) random_item();
		key_event(KEY_ESCAPE, LVL_PRESS);
		tick();
		key_event(KEY_ESCAPE, LVL_RELEASE);
		for (int i = 0; i < 20; i++) random_item();
		tick();
		wait_drained();

		$display("covered %0d requests and %0d setpoints over %0d register settings",
			tracker.requests_seen, tracker.setpoints_checked, settings_loaded);
		$display("diagonal ticks %0d, clamped axes %0d, halted at end %0b",
			tracker.diagonal_ticks, tracker.clamp_hits, tracker.frozen);
		if (tracker.mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
